>>> rtl/core/cbb_pkg.sv
package cbb_pkg;

	localparam int MAX_RADIUS = 31;
	localparam int RAD_W      = 5;
	localparam int HIST_AW    = 6;
	localparam int SEEN_W     = 7;
	localparam int SUM_W      = 14;
	localparam int TAP_W      = 6;
	localparam int DIV_STEPS  = SUM_W;
	localparam logic [SEEN_W-1:0] SEEN_MAX = 7'd127;

	typedef logic [31:0] pixel_t;

	// one output position handed from front to back
	typedef struct packed {
		logic [RAD_W-1:0]   offset;
		logic               last;
		logic [HIST_AW-1:0] head;
		logic [SEEN_W-1:0]  seen;
		logic [RAD_W-1:0]   radius;
		pixel_t             first;
	} job_t;

	// history write from front into the back's line memory
	typedef struct packed {
		logic               en;
		logic [HIST_AW-1:0] addr;
		pixel_t             data;
	} hist_wr_t;

	function automatic logic [RAD_W-1:0] eff_radius(input logic [RAD_W-1:0] v);
		logic [RAD_W-1:0] res;
		res = v;
		if (v == '0) res = RAD_W'(1);
		if (32'(v) > MAX_RADIUS) res = RAD_W'(MAX_RADIUS);
		return res;
	endfunction

endpackage

>>> rtl/core/cbb_job_fifo.sv
module cbb_job_fifo
	import cbb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output job_t pop_job,
	output logic empty,
	output logic full
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign pop_job = mem_q[rd_ptr_q];

	// two entry job store
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_ptr_q] <= push_job;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && !full) wr_ptr_q <= ~wr_ptr_q;
			if (pop && !empty) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/cbb_front.sv
module cbb_front
	import cbb_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           blur_radius_we,
	input  logic [RAD_W-1:0] blur_radius,
	input  logic           in_valid,
	output logic           in_ready,
	input  pixel_t         pix,
	input  logic           line_end,
	input  logic           fifo_empty,
	input  logic           fifo_full,
	input  logic           back_busy,
	output logic           push,
	output job_t           push_job,
	output hist_wr_t       hist_wr
);

	logic [RAD_W-1:0]   blur_q;
	logic [RAD_W-1:0]   radius_q;
	pixel_t             first_q;
	logic [SEEN_W-1:0]  seen_q;
	logic [SEEN_W-1:0]  jseen_q;
	logic [HIST_AW-1:0] head_q;
	logic               pend_q;
	logic [RAD_W-1:0]   pend_d_q;
	logic               pend_end_q;

	logic               accept;
	logic               start;
	logic [RAD_W-1:0]   r_line;
	logic [SEEN_W-1:0]  seen_n;
	logic [SEEN_W-1:0]  seen_m1;
	logic [RAD_W-1:0]   dmax;
	logic               emit_mid;

	// classify the incoming beat
	always_comb begin
		start   = (seen_q == '0);
		r_line  = start ? eff_radius(blur_q) : radius_q;
		if (start) seen_n = SEEN_W'(1);
		else if (seen_q == SEEN_MAX) seen_n = SEEN_MAX;
		else seen_n = seen_q + SEEN_W'(1);
		seen_m1  = seen_n - SEEN_W'(1);
		dmax     = (seen_m1 > {2'b00, r_line}) ? r_line : seen_m1[RAD_W-1:0];
		emit_mid = (seen_n >= ({2'b00, r_line} + SEEN_W'(1)));
	end

	assign in_ready = !pend_q && fifo_empty && !back_busy;
	assign accept   = in_valid && in_ready;
	assign push     = pend_q && !fifo_full;

	assign hist_wr.en   = accept;
	assign hist_wr.addr = head_q + HIST_AW'(1);
	assign hist_wr.data = pix;

	assign push_job.offset = pend_d_q;
	assign push_job.last   = pend_end_q && (pend_d_q == '0);
	assign push_job.head   = head_q;
	assign push_job.seen   = jseen_q;
	assign push_job.radius = radius_q;
	assign push_job.first  = first_q;

	// line state and job issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_q     <= RAD_W'(1);
			radius_q   <= RAD_W'(1);
			first_q    <= '0;
			seen_q     <= '0;
			jseen_q    <= '0;
			head_q     <= '0;
			pend_q     <= 1'b0;
			pend_d_q   <= '0;
			pend_end_q <= 1'b0;
		end else begin
			if (blur_radius_we) blur_q <= blur_radius;
			if (accept) begin
				head_q   <= head_q + HIST_AW'(1);
				radius_q <= r_line;
				jseen_q  <= seen_n;
				if (start) first_q <= pix;
				seen_q   <= line_end ? '0 : seen_n;
				if (line_end) begin
					pend_q     <= 1'b1;
					pend_d_q   <= dmax;
					pend_end_q <= 1'b1;
				end else if (emit_mid) begin
					pend_q     <= 1'b1;
					pend_d_q   <= r_line;
					pend_end_q <= 1'b0;
				end
			end else if (push) begin
				if (!pend_end_q || pend_d_q == '0) pend_q <= 1'b0;
				else pend_d_q <= pend_d_q - RAD_W'(1);
			end
		end
	end

endmodule

>>> rtl/core/cbb_back.sv
module cbb_back
	import cbb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  hist_wr_t hist_wr,
	input  logic     fifo_empty,
	input  job_t     pop_job,
	output logic     pop,
	output logic     busy,
	output logic     out_valid,
	input  logic     out_ready,
	output pixel_t   out_pix,
	output logic     out_last
);

	typedef enum logic [2:0] {IDLE, SUM, DRAIN, DIV, OUT} state_t;

	pixel_t             mem [2**HIST_AW];
	pixel_t             rd_q;
	state_t             state_q;
	job_t               job_q;
	logic [TAP_W-1:0]   tap_q;
	logic               tap_vld_s1;
	logic               tap_first_s1;
	logic [SUM_W-1:0]   acc_q [4];
	logic [SUM_W-1:0]   dvd_q [4];
	logic [5:0]         rem_q [4];
	logic [3:0]         step_q;

	logic signed [7:0]  k;
	logic [6:0]         kk;
	logic               use_first;
	logic [HIST_AW-1:0] rd_addr;
	logic [5:0]         divisor;
	logic [TAP_W-1:0]   tap_end;
	pixel_t             tap_pix;
	logic [6:0]         t [4];
	logic               ge [4];
	logic [6:0]         t_sub [4];

	// window tap address
	always_comb begin
		k = $signed({3'b000, job_q.offset}) - $signed({3'b000, job_q.radius})
			+ $signed({2'b00, tap_q});
		kk        = k[7] ? 7'd0 : k[6:0];
		use_first = (kk >= job_q.seen);
		rd_addr   = job_q.head - kk[HIST_AW-1:0];
		divisor   = {job_q.radius, 1'b1};
		tap_end   = {job_q.radius, 1'b0};
		tap_pix   = tap_first_s1 ? job_q.first : rd_q;
	end

	// one restoring step per channel
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			t[c]     = {rem_q[c], dvd_q[c][SUM_W-1]};
			ge[c]    = (t[c] >= {1'b0, divisor});
			t_sub[c] = t[c] - {1'b0, divisor};
		end
	end

	assign pop       = (state_q == IDLE) && !fifo_empty;
	assign busy      = (state_q == SUM) || (state_q == DRAIN) || (state_q == DIV);
	assign out_valid = (state_q == OUT);

	// line memory
	always_ff @(posedge clk) begin
		if (hist_wr.en) mem[hist_wr.addr] <= hist_wr.data;
		rd_q <= mem[rd_addr];
	end

	// sequencer, accumulate and divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			tap_vld_s1   <= 1'b0;
			tap_first_s1 <= 1'b0;
			tap_q        <= '0;
			step_q       <= '0;
			job_q        <= '0;
			out_last     <= 1'b0;
			out_pix      <= '0;
			for (int c = 0; c < 4; c++) begin
				acc_q[c] <= '0;
				dvd_q[c] <= '0;
				rem_q[c] <= '0;
			end
		end else begin
			tap_vld_s1   <= (state_q == SUM);
			tap_first_s1 <= use_first;
			if (tap_vld_s1) begin
				for (int c = 0; c < 4; c++)
					acc_q[c] <= acc_q[c] + SUM_W'(tap_pix[8*c +: 8]);
			end
			unique case (state_q)
				IDLE: begin
					if (!fifo_empty) begin
						job_q <= pop_job;
						tap_q <= '0;
						for (int c = 0; c < 4; c++) acc_q[c] <= '0;
						state_q <= SUM;
					end
				end
				SUM: begin
					if (tap_q == tap_end) state_q <= DRAIN;
					else tap_q <= tap_q + TAP_W'(1);
				end
				DRAIN: begin
					step_q <= '0;
					state_q <= DIV;
				end
				DIV: begin
					if (step_q == 4'd0) begin
						for (int c = 0; c < 4; c++) begin
							dvd_q[c] <= acc_q[c];
							rem_q[c] <= '0;
						end
						step_q <= 4'd1;
					end else begin
						for (int c = 0; c < 4; c++) begin
							rem_q[c] <= ge[c] ? t_sub[c][5:0] : t[c][5:0];
							dvd_q[c] <= {dvd_q[c][SUM_W-2:0], ge[c]};
						end
						if (step_q == 4'(DIV_STEPS)) state_q <= OUT;
						step_q <= step_q + 4'd1;
					end
				end
				OUT: begin
					if (out_ready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			if (state_q == DIV && step_q == 4'(DIV_STEPS)) begin
				for (int c = 0; c < 4; c++)
					out_pix[8*c +: 8] <= ((|dvd_q[c][SUM_W-2:7]) || (ge[c] && 1'b0))
						? 8'hFF : {dvd_q[c][6:0], ge[c]};
				out_last <= job_q.last;
			end
		end
	end

endmodule

>>> rtl/core/clamped_box_blur_line_pass.sv
// Clamped box blur, one line pass.
// Pixels of one line enter on the in channel (valid/ready), the last one
// flagged by line_end. Each blurred pixel leaves on the out channel
// (valid/ready); line_done marks the final pixel of the line.
// Output x is the channel mean over 2r+1 pixels centred on x, with the line
// ends repeated; it is produced once pixel x+r has arrived, and the pending
// r+1 outputs (fewer on short lines) follow the last pixel.
// Once the pixel that frees an output is taken, the window is summed one
// tap a cycle from the line memory (single read port), then a restoring
// divider (one load, 14 steps) per channel runs and out_valid rises.
// The input is held off while a window is queued, summed or divided, so a
// new pixel is taken only after the previous window is divided; the line
// end flush outputs are summed and divided one after another.
// blur_radius is to be written through blur_radius_we while idle (the block
// does not enforce it); it is latched at each line's first pixel, 0 acts as 1.
// Reset (arst_n low) clears line state, radius to 1 and drops out_valid.
// A stalled receiver holds the result register; the front deasserts
// in_ready while any position is pending or queued (two-entry queue).
module clamped_box_blur_line_pass
	import cbb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       blur_radius_we,
	input  logic [4:0] blur_radius,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] red_in,
	input  logic [7:0] green_in,
	input  logic [7:0] blue_in,
	input  logic [7:0] alpha_in,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out,
	output logic [7:0] alpha_out,
	output logic       line_done
);

	hist_wr_t hist_wr;
	job_t     push_job;
	job_t     pop_job;
	logic     push;
	logic     pop;
	logic     fifo_empty;
	logic     fifo_full;
	logic     back_busy;
	pixel_t   out_pix;

	// front: accept and classify
	cbb_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.blur_radius_we (blur_radius_we),
		.blur_radius    (blur_radius),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pix            ({alpha_in, blue_in, green_in, red_in}),
		.line_end       (line_end),
		.fifo_empty     (fifo_empty),
		.fifo_full      (fifo_full),
		.back_busy      (back_busy),
		.push           (push),
		.push_job       (push_job),
		.hist_wr        (hist_wr)
	);

	// job queue
	cbb_job_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.empty    (fifo_empty),
		.full     (fifo_full)
	);

	// back: window sum and divide
	cbb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.hist_wr    (hist_wr),
		.fifo_empty (fifo_empty),
		.pop_job    (pop_job),
		.pop        (pop),
		.busy       (back_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_pix    (out_pix),
		.out_last   (line_done)
	);

	assign red_out   = out_pix[7:0];
	assign green_out = out_pix[15:8];
	assign blue_out  = out_pix[23:16];
	assign alpha_out = out_pix[31:24];

	// no push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full) else $error("job pushed into full queue");

	// a pixel is only written while nothing reads the line memory
	a_accept_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> (fifo_empty && !back_busy))
		else $error("pixel accepted while window pending");

	// a pixel beat never coincides with queue traffic
	a_accept_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> !push) else $error("accept during job issue");

endmodule
